[sv/metq_pkg.sv]
// Package for the time-sorted MIDI event queue.
// Holds the store entry type, the sequencer states, item kinds and helpers.
// No dependencies.
package metq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;

    localparam logic [15:0] FPB_RESET = 16'd256;
    localparam logic [3:0]  NOTE_ON   = 4'h9;
    localparam logic [3:0]  NOTE_OFF  = 4'h8;
    localparam logic signed [31:0] FRAME_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FRAME_MIN = 32'sh8000_0000;

    // Item kinds.
    localparam logic [2:0] KIND_PUSH_PACKET = 3'd0;
    localparam logic [2:0] KIND_PUSH_NOTE   = 3'd1;
    localparam logic [2:0] KIND_ADVANCE     = 3'd2;
    localparam logic [2:0] KIND_READ        = 3'd3;
    localparam logic [2:0] KIND_CLEAR       = 3'd4;

    // One stored packet: bytes hold status in 7:0, data one in 15:8, data two in 23:16.
    typedef struct packed {
        logic [31:0] frame;
        logic [1:0]  len;
        logic [23:0] bytes;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RECOUNT_RD,
        ST_RECOUNT_CK,
        ST_READ_RD,
        ST_READ_CK,
        ST_NSCAN_RD,
        ST_NSCAN_CK,
        ST_DISPATCH,
        ST_FIND_RD,
        ST_FIND_CK,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_INS_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_ADV_RD,
        ST_ADV_CK,
        ST_DONE
    } state_t;

    // True when a frame lies before the block length.
    function automatic logic in_block(logic [31:0] f, logic [15:0] fpb);
        return $signed({f[31], f}) < $signed({17'b0, fpb});
    endfunction

endpackage

[sv/midi_event_time_queue.sv]
// Time-sorted MIDI event queue: top level with the entry memory and its sequencer.
// Depends on metq_pkg for the entry type, states, kinds and the in-block test.
//
// Usage: items arrive on the s_ stream (s_tvalid/s_tready/s_tdata), one result
// item per input item leaves on the m_ stream. The block length register is
// written through cfg_valid/cfg_ready/cfg_data while the block is idle; a write
// starts a recount pass of the store before the next item is taken.
// All entries live in one 64-entry memory with a registered read.
// Every pass over the store visits each entry with a read step, then a
// check or write-back step. A note push is an overlap scan followed by at
// most one removal and three inserts. The next item is accepted only once
// the sequencer is back in its idle state.
// After reset the store is empty and the block length is 256.
// The finished result waits in an output register; a new item is accepted
// while it waits, and the sequencer holds its next result until the
// receiver takes the pending one.
module midi_event_time_queue
    import metq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,      // frames_per_block
    input  logic         s_tvalid,
    output logic         s_tready,
    // kind[2:0], frame[34:3], duration[65:35], packet_length[67:66],
    // status_byte[75:68], data_byte_one[83:76], data_byte_two[91:84],
    // channel[95:92], note_number[102:96], on_velocity[109:103],
    // off_velocity[116:110], read_index[122:117], zero above
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_frame[31:0], entry_length[33:32], entry_status[41:34],
    // entry_data_one[49:42], entry_data_two[57:50], read_valid[58],
    // in_block_count[65:59], stored_count[72:66], dropped[73], zero above
    output logic [79:0]  m_tdata
);

    // Input field unpacking.
    logic [2:0]  in_kind;
    logic [31:0] in_frame;
    logic [30:0] in_duration;
    logic [1:0]  in_plen;
    logic [7:0]  in_status, in_data_one, in_data_two;
    logic [3:0]  in_channel;
    logic [6:0]  in_note, in_on_vel, in_off_vel;
    logic [5:0]  in_read_index;

    assign in_kind       = s_tdata[2:0];
    assign in_frame      = s_tdata[34:3];
    assign in_duration   = s_tdata[65:35];
    assign in_plen       = s_tdata[67:66];
    assign in_status     = s_tdata[75:68];
    assign in_data_one   = s_tdata[83:76];
    assign in_data_two   = s_tdata[91:84];
    assign in_channel    = s_tdata[95:92];
    assign in_note       = s_tdata[102:96];
    assign in_on_vel     = s_tdata[109:103];
    assign in_off_vel    = s_tdata[116:110];
    assign in_read_index = s_tdata[122:117];

    // Registers.
    state_t           state_reg, state_next;
    logic [15:0]      fpb_reg, fpb_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] newcnt_reg, newcnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] ins_pos_reg, ins_pos_next;
    logic [CNT_W-1:0] hit_pos_reg, hit_pos_next;
    logic [CNT_W-1:0] adv_n_reg, adv_n_next;
    entry_t           ins_reg, ins_next;
    entry_t           hit_reg, hit_next;
    entry_t           res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      end_reg, end_next;
    logic [1:0]       on_len_reg, on_len_next;
    logic [23:0]      on_bytes_reg, on_bytes_next;
    logic [23:0]      off_bytes_reg, off_bytes_next;
    logic             pend_rm_reg, pend_rm_next;
    logic             pend_fix_reg, pend_fix_next;
    logic             pend_mv_reg, pend_mv_next;
    logic             pend_on_reg, pend_on_next;
    logic             pend_off_reg, pend_off_next;
    logic             drop_reg, drop_next;
    logic             m_valid_reg, m_valid_next;
    logic [79:0]      m_data_reg, m_data_next;

    // Entry memory.
    entry_t           mem [CAPACITY];
    entry_t           rdata_reg;
    logic [IDX_W-1:0] mem_raddr, mem_waddr;
    logic             mem_we;
    entry_t           mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Shared decisions on the read entry and the insert candidate.
    logic             s_acc, cfg_acc, full, out_free;
    logic             rd_on_match, rd_off_match, rd_before_start, rd_after_start;
    logic             rd_before_end, rd_le_ins;
    logic [32:0]      end_sum, adv_diff;
    logic [31:0]      end_frame, adj_frame;
    logic [CNT_W-1:0] pos_plus_one, pos_minus_one, pos_plus_n;
    logic [23:0]      pkt_bytes;

    assign s_acc    = s_tvalid && s_tready;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign full     = occ_reg >= CNT_W'(CAPACITY);
    assign out_free = !m_valid_reg || m_tready;

    // Note-on and note-off of the current channel and note number.
    assign rd_on_match  = (rdata_reg.len == 2'd3) &&
                          (rdata_reg.bytes[7:0] == on_bytes_reg[7:0]) &&
                          (rdata_reg.bytes[15:8] == on_bytes_reg[15:8]);
    assign rd_off_match = (rdata_reg.len == 2'd3) &&
                          (rdata_reg.bytes[7:0] == off_bytes_reg[7:0]) &&
                          (rdata_reg.bytes[15:8] == off_bytes_reg[15:8]);

    assign rd_before_start = $signed(rdata_reg.frame) < $signed(start_reg);
    assign rd_after_start  = $signed(rdata_reg.frame) > $signed(start_reg);
    assign rd_before_end   = $signed(rdata_reg.frame) < $signed(end_reg);
    assign rd_le_ins       = $signed(rdata_reg.frame) <= $signed(ins_reg.frame);

    // Note end, saturated at the largest frame.
    assign end_sum   = {in_frame[31], in_frame} + {2'b0, in_duration};
    assign end_frame = (!end_sum[32] && end_sum[31]) ? FRAME_MAX : end_sum[31:0];

    // Frame moved back by one block, saturated at the smallest frame.
    assign adv_diff  = {rdata_reg.frame[31], rdata_reg.frame} - {17'b0, fpb_reg};
    assign adj_frame = (adv_diff[32] && !adv_diff[31]) ? FRAME_MIN : adv_diff[31:0];

    assign pos_plus_one  = pos_reg + CNT_W'(1);
    assign pos_minus_one = pos_reg - CNT_W'(1);
    assign pos_plus_n    = pos_reg + adv_n_reg;

    assign pkt_bytes = {(in_plen > 2'd2) ? in_data_two : 8'h00,
                        (in_plen > 2'd1) ? in_data_one : 8'h00,
                        (in_plen > 2'd0) ? in_status   : 8'h00};

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !s_tvalid;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_kind)
                        KIND_PUSH_PACKET: state_next = ST_DISPATCH;
                        KIND_PUSH_NOTE:   state_next = ST_NSCAN_RD;
                        KIND_ADVANCE:     state_next = ST_ADV_RD;
                        KIND_READ:        state_next = ST_READ_RD;
                        default:          state_next = ST_DONE;
                    endcase
                end else if (cfg_acc) begin
                    state_next = ST_RECOUNT_RD;
                end
            end
            ST_RECOUNT_RD: state_next = (pos_reg < occ_reg) ? ST_RECOUNT_CK : ST_IDLE;
            ST_RECOUNT_CK: state_next = ST_RECOUNT_RD;
            ST_READ_RD:    state_next = (pos_reg < occ_reg) ? ST_READ_CK : ST_DONE;
            ST_READ_CK:    state_next = ST_DONE;
            ST_NSCAN_RD:   state_next = (pos_reg < occ_reg) ? ST_NSCAN_CK : ST_DISPATCH;
            ST_NSCAN_CK: begin
                if (rd_before_start) begin
                    state_next = ST_NSCAN_RD;
                end else if (rd_on_match || (rd_off_match && rd_after_start)) begin
                    state_next = ST_DISPATCH;
                end else begin
                    state_next = ST_NSCAN_RD;
                end
            end
            ST_DISPATCH: begin
                if (pend_rm_reg) begin
                    state_next = ST_SHDN_RD;
                end else if (pend_fix_reg) begin
                    state_next = full ? ST_DISPATCH : ST_SHUP_RD;
                end else if (pend_mv_reg || pend_on_reg || pend_off_reg) begin
                    state_next = full ? ST_DISPATCH : ST_FIND_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FIND_RD: state_next = (pos_reg < occ_reg) ? ST_FIND_CK : ST_SHUP_RD;
            ST_FIND_CK: state_next = rd_le_ins ? ST_FIND_RD : ST_SHUP_RD;
            ST_SHUP_RD: state_next = (pos_reg > ins_pos_reg) ? ST_SHUP_WR : ST_INS_WR;
            ST_SHUP_WR: state_next = ST_SHUP_RD;
            ST_INS_WR:  state_next = ST_DISPATCH;
            ST_SHDN_RD: state_next = (pos_plus_one < occ_reg) ? ST_SHDN_WR : ST_DISPATCH;
            ST_SHDN_WR: state_next = ST_SHDN_RD;
            ST_ADV_RD:  state_next = (pos_plus_n < occ_reg) ? ST_ADV_CK : ST_DONE;
            ST_ADV_CK:  state_next = ST_ADV_RD;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result.
    always_comb begin
        fpb_next       = fpb_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        newcnt_next    = newcnt_reg;
        pos_next       = pos_reg;
        ins_pos_next   = ins_pos_reg;
        hit_pos_next   = hit_pos_reg;
        adv_n_next     = adv_n_reg;
        ins_next       = ins_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        on_len_next    = on_len_reg;
        on_bytes_next  = on_bytes_reg;
        off_bytes_next = off_bytes_reg;
        pend_rm_next   = pend_rm_reg;
        pend_fix_next  = pend_fix_reg;
        pend_mv_next   = pend_mv_reg;
        pend_on_next   = pend_on_reg;
        pend_off_next  = pend_off_reg;
        drop_next      = drop_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        mem_raddr      = pos_reg[IDX_W-1:0];
        mem_waddr      = pos_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_wdata      = rdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    pos_next       = '0;
                    newcnt_next    = '0;
                    drop_next      = 1'b0;
                    res_next       = '0;
                    res_valid_next = 1'b0;
                    pend_rm_next   = 1'b0;
                    pend_fix_next  = 1'b0;
                    pend_mv_next   = 1'b0;
                    pend_off_next  = 1'b0;
                    pend_on_next   = 1'b0;
                    start_next     = in_frame;
                    end_next       = end_frame;
                    adv_n_next     = cnt_reg;
                    off_bytes_next = {1'b0, in_off_vel, 1'b0, in_note, NOTE_OFF, in_channel};
                    on_bytes_next  = {1'b0, in_on_vel, 1'b0, in_note, NOTE_ON, in_channel};
                    on_len_next    = 2'd3;
                    case (in_kind)
                        KIND_PUSH_PACKET: begin
                            pend_on_next  = 1'b1;
                            on_len_next   = in_plen;
                            on_bytes_next = pkt_bytes;
                        end
                        KIND_READ: begin
                            pos_next = CNT_W'(in_read_index);
                        end
                        KIND_CLEAR: begin
                            occ_next = '0;
                            cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end else if (cfg_acc) begin
                    fpb_next    = cfg_data;
                    pos_next    = '0;
                    newcnt_next = '0;
                end
            end

            // Recount of in-block entries after a register write.
            ST_RECOUNT_RD: begin
                if (pos_reg >= occ_reg) begin
                    cnt_next = newcnt_reg;
                end
            end
            ST_RECOUNT_CK: begin
                if (in_block(rdata_reg.frame, fpb_reg)) begin
                    newcnt_next = newcnt_reg + CNT_W'(1);
                end
                pos_next = pos_plus_one;
            end

            ST_READ_CK: begin
                res_next       = rdata_reg;
                res_valid_next = 1'b1;
            end

            // Overlap scan for a note push.
            ST_NSCAN_RD: begin
                if (pos_reg >= occ_reg) begin
                    pend_on_next  = 1'b1;
                    pend_off_next = 1'b1;
                end
            end
            ST_NSCAN_CK: begin
                hit_pos_next = pos_reg;
                hit_next     = rdata_reg;
                pos_next     = pos_plus_one;
                if (!rd_before_start) begin
                    if (rd_on_match) begin
                        pend_on_next  = 1'b1;
                        pend_fix_next = rd_before_end;
                        pend_off_next = !rd_before_end;
                    end else if (rd_off_match && rd_after_start) begin
                        pend_rm_next  = 1'b1;
                        pend_mv_next  = 1'b1;
                        pend_on_next  = 1'b1;
                        pend_off_next = 1'b1;
                    end
                end
            end

            // Pick the next pending store operation.
            ST_DISPATCH: begin
                pos_next = '0;
                if (pend_rm_reg) begin
                    pend_rm_next = 1'b0;
                    pos_next     = hit_pos_reg;
                    if (in_block(hit_reg.frame, fpb_reg) && cnt_reg != '0) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end else if (pend_fix_reg) begin
                    pend_fix_next = 1'b0;
                    ins_next      = '{frame: hit_reg.frame, len: 2'd3, bytes: off_bytes_reg};
                    ins_pos_next  = hit_pos_reg;
                    pos_next      = occ_reg;
                    drop_next     = drop_reg || full;
                end else if (pend_mv_reg) begin
                    pend_mv_next = 1'b0;
                    ins_next     = '{frame: start_reg, len: hit_reg.len, bytes: hit_reg.bytes};
                    drop_next    = drop_reg || full;
                end else if (pend_on_reg) begin
                    pend_on_next = 1'b0;
                    ins_next     = '{frame: start_reg, len: on_len_reg, bytes: on_bytes_reg};
                    drop_next    = drop_reg || full;
                end else if (pend_off_reg) begin
                    pend_off_next = 1'b0;
                    ins_next      = '{frame: end_reg, len: 2'd3, bytes: off_bytes_reg};
                    drop_next     = drop_reg || full;
                end
            end

            // Sorted position search: after every entry of equal or smaller frame.
            ST_FIND_RD: begin
                if (pos_reg >= occ_reg) begin
                    ins_pos_next = pos_reg;
                end
            end
            ST_FIND_CK: begin
                if (rd_le_ins) begin
                    pos_next = pos_plus_one;
                end else begin
                    ins_pos_next = pos_reg;
                    pos_next     = occ_reg;
                end
            end

            // Open a gap by moving the tail up one entry, from the top down.
            ST_SHUP_RD: begin
                mem_raddr = pos_minus_one[IDX_W-1:0];
            end
            ST_SHUP_WR: begin
                mem_we   = 1'b1;
                pos_next = pos_minus_one;
            end
            ST_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = ins_pos_reg[IDX_W-1:0];
                mem_wdata = ins_reg;
                occ_next  = occ_reg + CNT_W'(1);
                if (in_block(ins_reg.frame, fpb_reg)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            // Close a gap by moving the tail down one entry.
            ST_SHDN_RD: begin
                mem_raddr = pos_plus_one[IDX_W-1:0];
                if (pos_plus_one >= occ_reg) begin
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            ST_SHDN_WR: begin
                mem_we   = 1'b1;
                pos_next = pos_plus_one;
            end

            // Advance: drop the in-block prefix and shift the rest back in time.
            ST_ADV_RD: begin
                mem_raddr = pos_plus_n[IDX_W-1:0];
                if (pos_plus_n >= occ_reg) begin
                    occ_next = occ_reg - adv_n_reg;
                    cnt_next = newcnt_reg;
                end
            end
            ST_ADV_CK: begin
                mem_we    = 1'b1;
                mem_wdata = '{frame: adj_frame, len: rdata_reg.len, bytes: rdata_reg.bytes};
                if (in_block(adj_frame, fpb_reg)) begin
                    newcnt_next = newcnt_reg + CNT_W'(1);
                end
                pos_next = pos_plus_one;
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, drop_reg, occ_reg, cnt_reg, res_valid_reg,
                                    res_reg.bytes[23:16], res_reg.bytes[15:8],
                                    res_reg.bytes[7:0], res_reg.len, res_reg.frame};
                end
            end

            default: begin
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fpb_reg      <= FPB_RESET;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            pend_rm_reg  <= 1'b0;
            pend_fix_reg <= 1'b0;
            pend_mv_reg  <= 1'b0;
            pend_on_reg  <= 1'b0;
            pend_off_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fpb_reg      <= fpb_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            pend_rm_reg  <= pend_rm_next;
            pend_fix_reg <= pend_fix_next;
            pend_mv_reg  <= pend_mv_next;
            pend_on_reg  <= pend_on_next;
            pend_off_reg <= pend_off_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        newcnt_reg    <= newcnt_next;
        pos_reg       <= pos_next;
        ins_pos_reg   <= ins_pos_next;
        hit_pos_reg   <= hit_pos_next;
        adv_n_reg     <= adv_n_next;
        ins_reg       <= ins_next;
        hit_reg       <= hit_next;
        res_reg       <= res_next;
        res_valid_reg <= res_valid_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        on_len_reg    <= on_len_next;
        on_bytes_reg  <= on_bytes_next;
        off_bytes_reg <= off_bytes_next;
        drop_reg      <= drop_next;
        m_data_reg    <= m_data_next;
    end

    // The store never holds more than its capacity.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    // An insert is only written into a store with room left.
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_WR) |-> (occ_reg < CNT_W'(CAPACITY)))
        else $error("insert into a full store");

    // The in-block count never exceeds the stored count between items.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg <= occ_reg))
        else $error("in-block count above stored count");

    // Memory writes happen only in the write-back states.
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_SHUP_WR || state_reg == ST_INS_WR ||
                    state_reg == ST_SHDN_WR || state_reg == ST_ADV_CK))
        else $error("memory write outside a write-back state");

    // A result is loaded only when the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_data_reg == $past(m_data_reg)))
        else $error("pending result overwritten");

endmodule

[sim/midi_event_time_queue_tb.sv]
// Testbench for the time-sorted MIDI event queue (midi_event_time_queue).
// Drives random and directed items, predicts every result with a local store model.
// Depends on metq_pkg and the RTL of the block.
module midi_event_time_queue_tb
    import metq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Packed from the highest bits down, so kind lands in the lowest bits.
    typedef struct packed {
        logic [5:0]  ridx;
        logic [6:0]  offv;
        logic [6:0]  onv;
        logic [6:0]  note;
        logic [3:0]  chan;
        logic [7:0]  d2;
        logic [7:0]  d1;
        logic [7:0]  st;
        logic [1:0]  plen;
        logic [30:0] duration;
        logic [31:0] frame;
        logic [2:0]  kind;
    } event_item_t;

    typedef struct packed {
        logic [31:0] frame;
        logic [1:0]  len;
        logic [7:0]  st;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic        rvalid;
        logic [6:0]  inblk;
        logic [6:0]  stored;
        logic        dropped;
    } queue_report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;

    midi_event_time_queue dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Local model of the store.
    logic signed [31:0] mf [CAPACITY];
    logic [1:0]         ml [CAPACITY];
    logic [23:0]        mb [CAPACITY];
    int                 occ = 0;
    int                 blk_cnt = 0;
    logic [15:0]        fpb = FPB_RESET;

    function automatic bit frame_in_block(logic signed [31:0] f);
        return longint'(f) < longint'(fpb);
    endfunction

    function automatic void recount_block();
        blk_cnt = 0;
        for (int i = 0; i < occ; i++) if (frame_in_block(mf[i])) blk_cnt++;
    endfunction

    function automatic bit store_insert(int pos, logic signed [31:0] f, logic [1:0] len,
                                        logic [23:0] b);
        if (occ >= CAPACITY || pos > occ) return 0;
        for (int i = occ; i > pos; i--) begin
            mf[i] = mf[i-1]; ml[i] = ml[i-1]; mb[i] = mb[i-1];
        end
        mf[pos] = f; ml[pos] = len; mb[pos] = b;
        occ++;
        if (frame_in_block(f)) blk_cnt++;
        return 1;
    endfunction

    function automatic void store_remove(int pos);
        if (frame_in_block(mf[pos]) && blk_cnt > 0) blk_cnt--;
        for (int i = pos; i < occ - 1; i++) begin
            mf[i] = mf[i+1]; ml[i] = ml[i+1]; mb[i] = mb[i+1];
        end
        occ--;
    endfunction

    function automatic bit store_push_sorted(logic signed [31:0] f, logic [1:0] len,
                                             logic [23:0] b);
        int pos;
        pos = 0;
        while (pos < occ && mf[pos] <= f) pos++;
        return store_insert(pos, f, len, b);
    endfunction

    function automatic bit entry_is_note(int i, logic [7:0] s, logic [6:0] n);
        return ml[i] == 2'd3 && mb[i][7:0] == s && mb[i][15:8] == {1'b0, n};
    endfunction

    function automatic bit store_push_note(event_item_t it);
        longint e;
        logic signed [31:0] start, fin, f;
        logic [7:0] on_st, off_st;
        logic [23:0] on_b, off_b, b;
        logic [1:0] len;
        bit ok;
        start = it.frame;
        e = longint'(start) + longint'(it.duration);
        fin = (e > longint'(FRAME_MAX)) ? FRAME_MAX : e[31:0];
        on_st = {NOTE_ON, it.chan};
        off_st = {NOTE_OFF, it.chan};
        on_b = {1'b0, it.onv, 1'b0, it.note, on_st};
        off_b = {1'b0, it.offv, 1'b0, it.note, off_st};
        ok = 1;
        for (int i = 0; i < occ; i++) begin
            f = mf[i];
            if (f < start) continue;
            if (entry_is_note(i, on_st, it.note)) begin
                if (f < fin) begin
                    ok &= store_insert(i, f, 2'd3, off_b);
                    ok &= store_push_sorted(start, 2'd3, on_b);
                    return ok;
                end
                break;
            end
            if (entry_is_note(i, off_st, it.note) && f > start) begin
                len = ml[i]; b = mb[i];
                store_remove(i);
                ok &= store_push_sorted(start, len, b);
                break;
            end
        end
        ok &= store_push_sorted(start, 2'd3, on_b);
        ok &= store_push_sorted(fin, 2'd3, off_b);
        return ok;
    endfunction

    function automatic queue_report_t predict_report(event_item_t it);
        queue_report_t r;
        longint v;
        int n;
        logic [23:0] b;
        r = '0;
        case (it.kind)
            KIND_PUSH_PACKET: begin
                b = '0;
                if (it.plen > 0) b[7:0] = it.st;
                if (it.plen > 1) b[15:8] = it.d1;
                if (it.plen > 2) b[23:16] = it.d2;
                r.dropped = !store_push_sorted(it.frame, it.plen, b);
            end
            KIND_PUSH_NOTE: r.dropped = !store_push_note(it);
            KIND_ADVANCE: begin
                n = (blk_cnt > occ) ? occ : blk_cnt;
                for (int i = 0; i < occ - n; i++) begin
                    mf[i] = mf[i+n]; ml[i] = ml[i+n]; mb[i] = mb[i+n];
                end
                occ -= n;
                for (int i = 0; i < occ; i++) begin
                    v = longint'(mf[i]) - longint'(fpb);
                    mf[i] = (v < longint'(FRAME_MIN)) ? FRAME_MIN : v[31:0];
                end
                recount_block();
            end
            KIND_READ: if (it.ridx < occ) begin
                r.frame = mf[it.ridx]; r.len = ml[it.ridx];
                r.st = mb[it.ridx][7:0]; r.d1 = mb[it.ridx][15:8];
                r.d2 = mb[it.ridx][23:16]; r.rvalid = 1'b1;
            end
            KIND_CLEAR: begin
                occ = 0; blk_cnt = 0;
            end
            default: ;
        endcase
        r.inblk = blk_cnt[6:0];
        r.stored = occ[6:0];
        return r;
    endfunction

    // Pending input items and expected reports.
    event_item_t   pending_items[$];
    queue_report_t expected_reports[$];
    int            mismatches = 0;
    int            item_gap = 0;
    int            report_gap = 0;
    int            hold_cycles = 0;
    int            hold_requests = 0;
    int            hold_seen = 0;
    int            idle_cycles = 0;
    bit            started = 0;

    // Driver: offers items from the queue with random gaps.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                void'(pending_items.pop_front());
                expected_reports.push_back(predict_report(event_item_t'(s_tdata[122:0])));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (item_gap > 0) begin
                    item_gap <= item_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, pending_items[0]};
                    item_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold, counted down in cycles on request.
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_cycles <= 3000;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Monitor: checks each report against the oldest prediction.
    always @(posedge aclk) begin
        queue_report_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[33:32], m_tdata[41:34], m_tdata[49:42],
                       m_tdata[57:50], m_tdata[58], m_tdata[65:59], m_tdata[72:66],
                       m_tdata[73]};
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected report %h", got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("report mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
            end else if (report_gap > 0) begin
                report_gap <= report_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    report_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // Watchdog on cycles with no handshake on the input, output or configuration port.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (started) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic event_item_t random_item();
        event_item_t it;
        logic [127:0] raw;
        int sel;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(event_item_t)-1:0];
        sel = $urandom_range(0, 99);
        it.kind = (sel < 35) ? KIND_PUSH_NOTE : (sel < 65) ? KIND_PUSH_PACKET :
                  (sel < 78) ? KIND_ADVANCE : (sel < 96) ? KIND_READ :
                  (sel < 98) ? KIND_CLEAR : 3'($urandom_range(5, 7));
        // Mostly small frames and durations so notes overlap and blocks matter.
        if ($urandom_range(0, 9) != 0) it.frame = 32'($urandom_range(0, 1200)) - 32'sd100;
        if ($urandom_range(0, 9) != 0) it.duration = 31'($urandom_range(0, 600));
        if ($urandom_range(0, 3) != 0) begin
            it.chan = 4'($urandom_range(0, 1));
            it.note = 7'($urandom_range(60, 62));
        end
        if ($urandom_range(0, 2) != 0) it.plen = 2'd3;
        if ($urandom_range(0, 2) == 0) begin
            it.st = {($urandom_range(0, 1) ? NOTE_ON : NOTE_OFF), 4'($urandom_range(0, 1))};
            it.d1 = 8'($urandom_range(60, 62));
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    task automatic write_block_length(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        fpb = value;
        recount_block();
    endtask

    initial begin
        event_item_t it;
        logic [15:0] settings[6] = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd100, 16'd300};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        started = 1;
        @(posedge aclk);

        // Directed: field extremes, every kind, overlaps, underflow.
        it = '0;
        it.kind = KIND_READ; pending_items.push_back(it);
        it.kind = KIND_PUSH_PACKET; it.frame = -32'sd5; it.plen = 2'd3;
        it.st = 8'hFF; it.d1 = 8'hFF; it.d2 = 8'hFF; pending_items.push_back(it);
        it.frame = FRAME_MAX; it.plen = 2'd1; pending_items.push_back(it);
        it.frame = FRAME_MIN; it.plen = 2'd2; pending_items.push_back(it);
        it.frame = 32'sd10; it.plen = 2'd0; pending_items.push_back(it);
        it = '0; it.kind = KIND_PUSH_NOTE; it.frame = 32'sd50; it.duration = 31'd100;
        it.chan = 4'hF; it.note = 7'h7F; it.onv = 7'h7F; it.offv = 7'h7F;
        pending_items.push_back(it);
        it.frame = 32'sd20; it.offv = 7'd1; pending_items.push_back(it);
        it.frame = 32'sd30; it.duration = 31'd10; pending_items.push_back(it);
        it.frame = 32'sd40; it.duration = '1; pending_items.push_back(it);
        it = '0; it.kind = KIND_READ;
        for (int i = 0; i < 4; i++) begin
            it.ridx = 6'(i); pending_items.push_back(it);
        end
        it.ridx = 6'h3F; pending_items.push_back(it);
        it.kind = KIND_ADVANCE; pending_items.push_back(it);
        it.kind = 3'd7; pending_items.push_back(it);
        it.kind = KIND_CLEAR; pending_items.push_back(it);
        wait_drained();

        // Fill beyond capacity with the receiver held off, so the input stalls.
        hold_requests++;
        it = '0; it.kind = KIND_PUSH_PACKET; it.plen = 2'd3;
        for (int i = 0; i < 70; i++) begin
            it.frame = 32'($urandom_range(0, 500)); pending_items.push_back(it);
        end
        it.kind = KIND_PUSH_NOTE; pending_items.push_back(it);
        it.kind = KIND_ADVANCE; pending_items.push_back(it);
        it.kind = KIND_CLEAR; pending_items.push_back(it);
        wait_drained();

        // Random phases under several block lengths.
        for (int p = 0; p < 6; p++) begin
            write_block_length(settings[p]);
            for (int i = 0; i < 280; i++) pending_items.push_back(random_item());
            wait_drained();
        end

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
